FILE: rtl/hsk_pkg.sv
// shared types and constants for the six-key report builder
package hsk_pkg;

  localparam int unsigned SHOWN_SLOTS = 6;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // event kinds
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_LONG    = 2'd1;
  localparam logic [1:0] CMD_REPEAT  = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  // lighting hints
  localparam logic [1:0] LED_NONE    = 2'd0;
  localparam logic [1:0] LED_PRESS   = 2'd1;
  localparam logic [1:0] LED_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD = 2'd3;

  // reset values
  localparam logic [CODE_W-1:0] RST_CODE = 8'h53;
  localparam logic [POS_W-1:0]  RST_ROW  = 4'd0;
  localparam logic [POS_W-1:0]  RST_COL  = 4'd0;
  localparam logic [HOLD_W-1:0] RST_HOLD = 16'd1000;
  localparam logic [CODE_W-1:0] EMPTY_CODE = 8'h00;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [HOLD_W-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic [SHOWN_SLOTS-1:0][CODE_W-1:0] slots;
    logic                               mode_next;
    logic [1:0]                         led_event;
    logic [POS_W-1:0]                   led_row;
    logic [POS_W-1:0]                   led_col;
  } res_t;

endpackage

FILE: rtl/hsk_cfg_regs.sv
// special key configuration registers
module hsk_cfg_regs
  import hsk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code    <= RST_CODE;
      cfg.row     <= RST_ROW;
      cfg.col     <= RST_COL;
      cfg.hold_ms <= RST_HOLD;
    end else if (wr_en) begin
      case (wr_index)
        REG_CODE: cfg.code    <= wr_data[CODE_W-1:0];
        REG_ROW:  cfg.row     <= wr_data[POS_W-1:0];
        REG_COL:  cfg.col     <= wr_data[POS_W-1:0];
        REG_HOLD: cfg.hold_ms <= wr_data[HOLD_W-1:0];
        default:  cfg.hold_ms <= cfg.hold_ms;
      endcase
    end
  end

endmodule

FILE: rtl/hsk_in_stage.sv
// input register for one key event word
module hsk_in_stage
  import hsk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  evt_t evt_in,
  output logic evt_valid,
  output evt_t evt
);

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else begin
      evt_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      evt <= evt_in;
    end
  end

endmodule

FILE: rtl/hsk_report_core.sv
// report slot state, special key tracking and result register
module hsk_report_core
  import hsk_pkg::*;
#(
  parameter int unsigned REPORT_SLOTS = 6
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic evt_valid,
  input  evt_t evt,
  output logic res_valid,
  output res_t res
);

  logic [CODE_W-1:0] slots      [REPORT_SLOTS];
  logic [CODE_W-1:0] slots_next [REPORT_SLOTS];
  logic [TIME_W-1:0] press_time;
  logic [TIME_W-1:0] press_time_next;
  logic              long_handled;
  logic              long_handled_next;
  res_t              res_next;

  logic              special;
  logic              do_insert;
  logic              do_clear;
  logic [TIME_W-1:0] held;
  logic              placed;
  logic              mode_req;
  logic [1:0]        led;

  assign special = (evt.row == cfg.row) && (evt.col == cfg.col) && (evt.code == cfg.code);
  assign held    = evt.now_ms - press_time;

  // event decode
  always_comb begin
    do_insert         = 1'b0;
    do_clear          = 1'b0;
    mode_req          = 1'b0;
    led               = LED_NONE;
    press_time_next   = press_time;
    long_handled_next = long_handled;
    case (evt.cmd)
      CMD_PRESS: begin
        if (special) begin
          press_time_next   = evt.now_ms;
          long_handled_next = 1'b0;
        end
        do_insert = 1'b1;
        led       = LED_PRESS;
      end
      CMD_LONG: begin
        if (special && !long_handled) begin
          mode_req          = 1'b1;
          long_handled_next = 1'b1;
        end else begin
          do_insert = 1'b1;
          led       = LED_PRESS;
        end
      end
      CMD_REPEAT: begin
        do_insert = !special;
      end
      CMD_RELEASE: begin
        // special release only passes if short and no long press was handled
        if (!special || ((held < {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_ms}) && !long_handled)) begin
          do_clear = 1'b1;
          led      = LED_RELEASE;
        end
      end
      default: begin
        do_insert = 1'b0;
      end
    endcase
  end

  // slot update: lowest empty slot on insert, every match on clear
  always_comb begin
    placed = 1'b0;
    for (int j = 0; j < REPORT_SLOTS; j++) begin
      slots_next[j] = slots[j];
      if (do_insert && !placed && (slots[j] == EMPTY_CODE)) begin
        slots_next[j] = evt.code;
        placed        = 1'b1;
      end
      if (do_clear && (slots[j] == evt.code)) begin
        slots_next[j] = EMPTY_CODE;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < SHOWN_SLOTS; k++) begin
      res_next.slots[k] = EMPTY_CODE;
    end
    for (int k = 0; k < SHOWN_SLOTS; k++) begin
      if (k < REPORT_SLOTS) begin
        res_next.slots[k] = slots_next[k];
      end
    end
    res_next.mode_next = mode_req;
    res_next.led_event = led;
    res_next.led_row   = (led != LED_NONE) ? evt.row : '0;
    res_next.led_col   = (led != LED_NONE) ? evt.col : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < REPORT_SLOTS; j++) begin
        slots[j] <= EMPTY_CODE;
      end
      press_time   <= '0;
      long_handled <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= evt_valid;
      if (evt_valid) begin
        for (int j = 0; j < REPORT_SLOTS; j++) begin
          slots[j] <= slots_next[j];
        end
        press_time   <= press_time_next;
        long_handled <= long_handled_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid) begin
      res <= res_next;
    end
  end

endmodule

FILE: rtl/hid_six_key_report_builder.sv
// top level of the six-key report builder with special mode key
// a word taken is registered in the input stage, then its result in the core's result
//   register, which drives the outputs with done high
// throughput: one word every clock, busy is always low
// reset: rst empties the report, clears the special key timing, loads the default config
// the receiver cannot stall, every result is shown for exactly one cycle
module hid_six_key_report_builder
  import hsk_pkg::*;
#(
  parameter int unsigned REPORT_SLOTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd,
  input  logic [POS_W-1:0]      key_row,
  input  logic [POS_W-1:0]      key_col,
  input  logic [CODE_W-1:0]     key_usage,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  done,
  output logic [CODE_W-1:0]     slot_0,
  output logic [CODE_W-1:0]     slot_1,
  output logic [CODE_W-1:0]     slot_2,
  output logic [CODE_W-1:0]     slot_3,
  output logic [CODE_W-1:0]     slot_4,
  output logic [CODE_W-1:0]     slot_5,
  output logic                  mode_next,
  output logic [1:0]            led_event,
  output logic [POS_W-1:0]      led_row,
  output logic [POS_W-1:0]      led_col
);

  cfg_t cfg;
  evt_t evt_in;
  evt_t evt;
  logic evt_valid;
  res_t res;

  assign busy = 1'b0;

  assign evt_in.cmd    = cmd;
  assign evt_in.row    = key_row;
  assign evt_in.col    = key_col;
  assign evt_in.code   = key_usage;
  assign evt_in.now_ms = now_ms;

  hsk_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  hsk_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .take      (start && !busy),
    .evt_in    (evt_in),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  hsk_report_core #(
    .REPORT_SLOTS (REPORT_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .evt_valid (evt_valid),
    .evt       (evt),
    .res_valid (done),
    .res       (res)
  );

  assign slot_0    = res.slots[0];
  assign slot_1    = res.slots[1];
  assign slot_2    = res.slots[2];
  assign slot_3    = res.slots[3];
  assign slot_4    = res.slots[4];
  assign slot_5    = res.slots[5];
  assign mode_next = res.mode_next;
  assign led_event = res.led_event;
  assign led_row   = res.led_row;
  assign led_col   = res.led_col;

endmodule

FILE: rtl/hsk_checker.sv
// port level checks for the six-key report builder
module hsk_checker
  import hsk_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             mode_next,
  input logic [1:0]       led_event,
  input logic [POS_W-1:0] led_row,
  input logic [POS_W-1:0] led_col
);

  // every accepted word gives its result, with done high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result word missing after accepted event");

  // no result without an accepted word before it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result word without a matching event");

  // no hint means no position
  a_hint_pos: assert property (@(posedge clk) disable iff (rst)
    (done && led_event == LED_NONE) |-> (led_row == '0 && led_col == '0))
    else $error("hint position set without a hint");

  // a mode request swallows the hint
  a_mode_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && mode_next) |-> (led_event == LED_NONE))
    else $error("mode request came with a lighting hint");

  a_hint_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (led_event == LED_NONE || led_event == LED_PRESS || led_event == LED_RELEASE))
    else $error("undefined lighting hint");

endmodule

bind hid_six_key_report_builder hsk_checker u_hsk_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .mode_next (mode_next),
  .led_event (led_event),
  .led_row   (led_row),
  .led_col   (led_col)
);

FILE: tb/hsk_report_checker.sv
// result checker for the six-key report builder: tracks events, predicts reports, compares
module hsk_report_checker
  import hsk_pkg::*;
#(
  parameter int unsigned REPORT_SLOTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            cmd,
  input  logic [POS_W-1:0]      key_row,
  input  logic [POS_W-1:0]      key_col,
  input  logic [CODE_W-1:0]     key_usage,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  done,
  input  logic [CODE_W-1:0]     slot_0,
  input  logic [CODE_W-1:0]     slot_1,
  input  logic [CODE_W-1:0]     slot_2,
  input  logic [CODE_W-1:0]     slot_3,
  input  logic [CODE_W-1:0]     slot_4,
  input  logic [CODE_W-1:0]     slot_5,
  input  logic                  mode_next,
  input  logic [1:0]            led_event,
  input  logic [POS_W-1:0]      led_row,
  input  logic [POS_W-1:0]      led_col,
  output int                    mismatches,
  output int                    pending
);

  logic [CODE_W-1:0] report [REPORT_SLOTS];
  logic [TIME_W-1:0] special_down_at;
  logic              special_long_seen;
  cfg_t              cfg;
  res_t              expected_reports [$];

  function automatic void insert_code(input logic [CODE_W-1:0] code);
    bit placed;
    placed = 1'b0;
    for (int j = 0; j < REPORT_SLOTS; j++) begin
      if (!placed && report[j] == EMPTY_CODE) begin
        report[j] = code;
        placed = 1'b1;
      end
    end
  endfunction

  function automatic void clear_code(input logic [CODE_W-1:0] code);
    for (int j = 0; j < REPORT_SLOTS; j++) begin
      if (report[j] == code) report[j] = EMPTY_CODE;
    end
  endfunction

  // applies one event to the tracked report and returns what the block should show
  function automatic res_t build_report(input evt_t e);
    res_t              r;
    logic              special;
    logic              passes;
    logic [TIME_W-1:0] held;
    r = '0;
    special = (e.row == cfg.row) && (e.col == cfg.col) && (e.code == cfg.code);
    case (e.cmd)
      CMD_PRESS: begin
        if (special) begin
          special_down_at   = e.now_ms;
          special_long_seen = 1'b0;
        end
        insert_code(e.code);
        r.led_event = LED_PRESS;
      end
      CMD_LONG: begin
        if (special && !special_long_seen) begin
          r.mode_next       = 1'b1;
          special_long_seen = 1'b1;
        end else begin
          insert_code(e.code);
          r.led_event = LED_PRESS;
        end
      end
      CMD_REPEAT: begin
        if (!special) insert_code(e.code);
      end
      default: begin
        passes = 1'b1;
        if (special) begin
          held   = e.now_ms - special_down_at;
          passes = (held < {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_ms}) && !special_long_seen;
        end
        if (passes) begin
          clear_code(e.code);
          r.led_event = LED_RELEASE;
        end
      end
    endcase
    for (int j = 0; j < SHOWN_SLOTS; j++) begin
      if (j < REPORT_SLOTS) r.slots[j] = report[j];
    end
    if (r.led_event != LED_NONE) begin
      r.led_row = e.row;
      r.led_col = e.col;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    evt_t e;
    res_t got;
    res_t want;
    if (rst) begin
      for (int j = 0; j < REPORT_SLOTS; j++) report[j] = EMPTY_CODE;
      special_down_at   = '0;
      special_long_seen = 1'b0;
      cfg               = {RST_CODE, RST_ROW, RST_COL, RST_HOLD};
      expected_reports.delete();
      mismatches        = 0;
    end else begin
      // compare first: a word accepted at this edge cannot be the one shown now
      if (done) begin
        got = {slot_5, slot_4, slot_3, slot_2, slot_1, slot_0,
               mode_next, led_event, led_row, led_col};
        if (expected_reports.size() == 0) begin
          $error("report shown with no event waiting");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          for (int j = 0; j < SHOWN_SLOTS; j++)
            check_field($sformatf("slot_%0d", j), 32'(want.slots[j]), 32'(got.slots[j]));
          check_field("mode_next", 32'(want.mode_next), 32'(got.mode_next));
          check_field("led_event", 32'(want.led_event), 32'(got.led_event));
          check_field("led_row", 32'(want.led_row), 32'(got.led_row));
          check_field("led_col", 32'(want.led_col), 32'(got.led_col));
        end
      end
      if (start && !busy) begin
        e = {cmd, key_row, key_col, key_usage, now_ms};
        expected_reports.push_back(build_report(e));
      end
      if (wr_en) begin
        case (wr_index)
          REG_CODE: cfg.code    = wr_data[CODE_W-1:0];
          REG_ROW:  cfg.row     = wr_data[POS_W-1:0];
          REG_COL:  cfg.col     = wr_data[POS_W-1:0];
          REG_HOLD: cfg.hold_ms = wr_data[HOLD_W-1:0];
          default:  ;
        endcase
      end
    end
    pending = expected_reports.size();
  end

endmodule

FILE: tb/tb_top.sv
// top of the report builder testbench: clock, reset, key event stimulus and verdict
module tb_top;
  import hsk_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            cmd;
  logic [POS_W-1:0]      key_row;
  logic [POS_W-1:0]      key_col;
  logic [CODE_W-1:0]     key_usage;
  logic [TIME_W-1:0]     now_ms;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  logic                  done;
  logic [CODE_W-1:0]     slot_0, slot_1, slot_2, slot_3, slot_4, slot_5;
  logic                  mode_next;
  logic [1:0]            led_event;
  logic [POS_W-1:0]      led_row;
  logic [POS_W-1:0]      led_col;
  int                    mismatches;
  int                    pending;

  // special key settings as last written, so the stimulus can aim at it
  logic [CODE_W-1:0]     sp_code;
  logic [POS_W-1:0]      sp_row;
  logic [POS_W-1:0]      sp_col;
  logic [HOLD_W-1:0]     sp_hold;
  logic [TIME_W-1:0]     tick;
  logic [CODE_W-1:0]     code_pool [8];
  bit                    burst;
  int                    events_sent;

  hid_six_key_report_builder uut (
    .clk, .rst, .start, .busy, .cmd, .key_row, .key_col, .key_usage, .now_ms,
    .wr_en, .wr_index, .wr_data, .done,
    .slot_0, .slot_1, .slot_2, .slot_3, .slot_4, .slot_5,
    .mode_next, .led_event, .led_row, .led_col
  );

  hsk_report_checker checker_i (
    .clk, .rst, .start, .busy, .cmd, .key_row, .key_col, .key_usage, .now_ms,
    .wr_en, .wr_index, .wr_data, .done,
    .slot_0, .slot_1, .slot_2, .slot_3, .slot_4, .slot_5,
    .mode_next, .led_event, .led_row, .led_col,
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // entered and left just after a falling edge; start stays high on the way out
  task automatic send_key(input logic [1:0] c, input logic [POS_W-1:0] r,
                          input logic [POS_W-1:0] k, input logic [CODE_W-1:0] code,
                          input logic [TIME_W-1:0] t);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    cmd       <= c;
    key_row   <= r;
    key_col   <= k;
    key_usage <= code;
    now_ms    <= t;
    do @(posedge clk); while (busy);
    @(negedge clk);
    events_sent++;
    if ($urandom_range(0, 39) == 0) burst = !burst;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_config(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] k, input logic [HOLD_W-1:0] hold);
    drain();
    wr_en    <= 1'b1;
    wr_index <= REG_CODE;
    wr_data  <= {{(CFG_DATA_W-CODE_W){1'b0}}, code};
    @(negedge clk);
    wr_index <= REG_ROW;
    wr_data  <= {{(CFG_DATA_W-POS_W){1'b0}}, r};
    @(negedge clk);
    wr_index <= REG_COL;
    wr_data  <= {{(CFG_DATA_W-POS_W){1'b0}}, k};
    @(negedge clk);
    wr_index <= REG_HOLD;
    wr_data  <= hold;
    @(negedge clk);
    wr_en    <= 1'b0;
    sp_code = code;
    sp_row  = r;
    sp_col  = k;
    sp_hold = hold;
    for (int j = 0; j < 8; j++) code_pool[j] = 8'($urandom_range(1, 255));
    // keep the special code in play now and then
    code_pool[7] = code;
  endtask

  // press, repeats and long presses of the special key, then a release near the threshold or at a random time
  task automatic special_session();
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] delta;
    int                n;
    tick = tick + $urandom_range(1, 100);
    t0   = tick;
    send_key(CMD_PRESS, sp_row, sp_col, sp_code, t0);
    n = $urandom_range(0, 2);
    repeat (n) send_key(CMD_REPEAT, sp_row, sp_col, sp_code, t0 + $urandom_range(0, 50));
    n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2);
    repeat (n) send_key(CMD_LONG, sp_row, sp_col, sp_code, t0 + $urandom_range(0, 50));
    case ($urandom_range(0, 5))
      0: delta = {16'd0, sp_hold} - 1;
      1: delta = {16'd0, sp_hold};
      2: delta = {16'd0, sp_hold} + 1;
      3: delta = $urandom;
      default: delta = $urandom_range(0, sp_hold);
    endcase
    tick = t0 + delta;
    send_key(CMD_RELEASE, sp_row, sp_col, sp_code, tick);
  endtask

  task automatic random_event();
    int                sel;
    logic [1:0]        c;
    logic [POS_W-1:0]  r;
    logic [POS_W-1:0]  k;
    logic [CODE_W-1:0] code;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) tick = $urandom;
    else tick = tick + $urandom_range(0, 60);
    if (sel < 30) begin
      special_session();
    end else if (sel < 85) begin
      sel = $urandom_range(0, 99);
      c = sel < 45 ? CMD_PRESS : sel < 80 ? CMD_RELEASE : sel < 90 ? CMD_REPEAT : CMD_LONG;
      r = 4'($urandom);
      k = 4'($urandom);
      code = code_pool[3'($urandom_range(0, 7))];
      // near misses on the special key: right place, code from the pool, which may match too
      if ($urandom_range(0, 9) == 0) begin
        r = sp_row;
        k = sp_col;
      end
      send_key(c, r, k, code, tick);
    end else begin
      send_key(2'($urandom), 4'($urandom), 4'($urandom), 8'($urandom), $urandom);
    end
  endtask

  initial begin
    int phase_end;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = CMD_PRESS;
    key_row   = '0;
    key_col   = '0;
    key_usage = '0;
    now_ms    = '0;
    wr_en     = 1'b0;
    wr_index  = REG_CODE;
    wr_data   = '0;
    sp_code   = RST_CODE;
    sp_row    = RST_ROW;
    sp_col    = RST_COL;
    sp_hold   = RST_HOLD;
    tick      = '0;
    burst     = 1'b0;
    events_sent = 0;
    for (int j = 0; j < 8; j++) code_pool[j] = 8'($urandom_range(1, 255));
    code_pool[7] = RST_CODE;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the report, overflow it, duplicates via repeat, code zero
    send_key(CMD_PRESS, 4'd1, 4'd2, 8'h04, 32'd0);
    send_key(CMD_PRESS, 4'd2, 4'd3, 8'h05, 32'd1);
    send_key(CMD_PRESS, 4'd3, 4'd4, 8'h06, 32'd2);
    send_key(CMD_PRESS, 4'd4, 4'd5, 8'h07, 32'd3);
    send_key(CMD_PRESS, 4'd5, 4'd6, 8'h08, 32'd4);
    send_key(CMD_PRESS, 4'd6, 4'd7, 8'h09, 32'd5);
    send_key(CMD_PRESS, 4'd15, 4'd15, 8'h0A, 32'd6);
    send_key(CMD_REPEAT, 4'd1, 4'd2, 8'h04, 32'd7);
    send_key(CMD_RELEASE, 4'd1, 4'd2, 8'h04, 32'd8);
    send_key(CMD_REPEAT, 4'd2, 4'd3, 8'h05, 32'd9);
    send_key(CMD_RELEASE, 4'd2, 4'd3, 8'h05, 32'd10);
    send_key(CMD_PRESS, 4'd3, 4'd3, 8'h00, 32'd11);
    send_key(CMD_RELEASE, 4'd3, 4'd3, 8'h00, 32'd12);
    // special key: release with no press measures from zero
    send_key(CMD_RELEASE, RST_ROW, RST_COL, RST_CODE, 32'd500);
    // long press handled once, second one inserts, repeat ignored, release swallowed
    send_key(CMD_PRESS, RST_ROW, RST_COL, RST_CODE, 32'hFFFF_FF00);
    send_key(CMD_LONG, RST_ROW, RST_COL, RST_CODE, 32'hFFFF_FF01);
    send_key(CMD_LONG, RST_ROW, RST_COL, RST_CODE, 32'hFFFF_FF02);
    send_key(CMD_REPEAT, RST_ROW, RST_COL, RST_CODE, 32'hFFFF_FF03);
    send_key(CMD_RELEASE, RST_ROW, RST_COL, RST_CODE, 32'hFFFF_FF10);
    // hold time across the tick wrap, then exactly at the threshold
    send_key(CMD_PRESS, RST_ROW, RST_COL, RST_CODE, 32'hFFFF_FFF0);
    send_key(CMD_RELEASE, RST_ROW, RST_COL, RST_CODE, 32'h0000_0010);
    send_key(CMD_PRESS, RST_ROW, RST_COL, RST_CODE, 32'd100);
    send_key(CMD_RELEASE, RST_ROW, RST_COL, RST_CODE, 32'd1100);
    send_key(CMD_PRESS, 4'd1, RST_COL, RST_CODE, 32'd1200);
    send_key(CMD_PRESS, 4'd15, 4'd15, 8'hFF, 32'hFFFF_FFFF);
    send_key(CMD_RELEASE, 4'd15, 4'd15, 8'hFF, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: ;
        1: load_config(8'h00, 4'd0, 4'd0, 16'd0);
        2: load_config(8'hFF, 4'd15, 4'd15, 16'hFFFF);
        3: load_config(8'($urandom), 4'($urandom), 4'($urandom),
                       16'($urandom_range(1, 50)));
        4: load_config(8'($urandom), 4'($urandom), 4'($urandom), 16'd1000);
        5: load_config(RST_CODE, RST_ROW, RST_COL, 16'd1);
        default: load_config(8'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
      endcase
      burst = (phase % 3) == 1;
      phase_end = events_sent + 250;
      while (events_sent < phase_end) random_event();
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hsk_pkg.sv
rtl/hsk_cfg_regs.sv
rtl/hsk_in_stage.sv
rtl/hsk_report_core.sv
rtl/hid_six_key_report_builder.sv
rtl/hsk_checker.sv
tb/hsk_report_checker.sv
tb/tb_top.sv
